FILE: hdl/cdew_pkg.sv
// Shared constants for the coupling difference / exponential weight block.
// No dependencies; imported by every module of the block.
`default_nettype none

package cdew_pkg;

  localparam int unsigned MAX_LANES = 4;
  localparam int unsigned LANES_DEF = 4;
  localparam int unsigned FRAC_DEF  = 16;

  // pipeline depth and stage map of one lane
  localparam int unsigned ST_DIFF  = 0;
  localparam int unsigned ST_SQ    = 1;
  localparam int unsigned ST_GPROD = 2;
  localparam int unsigned ST_MAG   = 3;
  localparam int unsigned ST_LOG2  = 4;
  localparam int unsigned ST_FRAC  = 5;
  localparam int unsigned ST_HORN  = 6;   // 8 steps, two stages each
  localparam int unsigned HORN_STEPS = 8;
  localparam int unsigned ST_HLAST = ST_HORN + 2 * HORN_STEPS - 1;
  localparam int unsigned ST_EXP   = ST_HLAST + 1;
  localparam int unsigned ST_WPROD = ST_EXP + 1;
  localparam int unsigned ST_OUT   = ST_WPROD + 1;
  localparam int unsigned NSTG     = ST_OUT + 1;

  localparam logic [31:0] Q30_ONE   = 32'd1073741824;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

  localparam logic [31:0] GAIN_RST  = 32'hFFFF_FD71;  // -655

  localparam logic [31:0] S32_MAX   = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN   = 32'h8000_0000;

endpackage

`default_nettype wire

FILE: hdl/cdew_ctl.sv
// Beat control for the lane pipeline: per-stage valid bits and load enables.
// Depends on cdew_pkg.
`default_nettype none

module cdew_ctl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cdew_pkg::NSTG-1:0] en_o
);
  import cdew_pkg::*;

  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] valid_d;
  logic [NSTG-1:0] ready;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ready[NSTG-1] = !valid_q[NSTG-1] || !out_stall_i;
    for (int s = NSTG - 2; s >= 0; s--) begin
      ready[s] = !valid_q[s] || ready[s+1];
    end
  end

  always_comb begin
    for (int s = 0; s < NSTG; s++) begin
      if (s == 0) begin
        en_o[s]    = ready[s] && in_valid_i;
        valid_d[s] = ready[s] ? in_valid_i : valid_q[s];
      end else begin
        en_o[s]    = ready[s] && valid_q[s-1];
        valid_d[s] = ready[s] ? valid_q[s-1] : valid_q[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !ready[0];
  assign out_valid_o = valid_q[NSTG-1];

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> valid_q[0])
    else $error("accepted beat lost at pipeline entry");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_last_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NSTG-1] && out_stall_i) |-> !en_o[NSTG-1])
    else $error("output stage overwritten while stalled");

endmodule

`default_nettype wire

FILE: hdl/cdew_lane.sv
// One lane: saturated difference, exp(gain*d*d) by base-2 split and Horner
// series, then the saturated weight. Depends on cdew_pkg.
`default_nettype none

module cdew_lane #(
  parameter int unsigned FracBits = cdew_pkg::FRAC_DEF
) (
  input  logic                      clk_i,
  input  logic [cdew_pkg::NSTG-1:0] en_i,
  input  logic [31:0]               gain_i,
  input  logic [31:0]               vi_i,
  input  logic [31:0]               vj_i,
  output logic [31:0]               diff_o,
  output logic [31:0]               weight_o
);
  import cdew_pkg::*;

  localparam int unsigned SW  = 2 * FracBits + 6;  // clamped d*d width
  localparam int unsigned SH  = SW / 2;
  localparam int unsigned SHW = SW - SH;
  localparam int unsigned PW  = 32 + SW;
  localparam int unsigned MW  = FracBits + 6;      // |x| up to 32.0
  localparam int unsigned YW  = MW + 1;
  localparam int unsigned NW  = YW - FracBits;
  localparam int unsigned EW  = 32 + FracBits;     // exp result width
  localparam int unsigned EH  = EW / 2;
  localparam int unsigned EHW = EW - EH;
  localparam int unsigned XW  = 32 + EW;

  localparam logic [SW-1:0] SCap = ((SW'(32) << FracBits) | SW'(1)) << FracBits;
  localparam logic [MW-1:0] XCap = MW'(32) << FracBits;
  localparam logic [EW-1:0] ECap = EW'(1) << (31 + FracBits);

  logic [31:0] d_q [0:ST_WPROD];
  logic [31:0] gm;
  logic        gneg;

  assign gneg = gain_i[31];
  assign gm   = gneg ? 32'(-gain_i) : gain_i;

  // difference, saturated
  logic [32:0] dx;
  logic [31:0] d0;
  always_comb begin
    dx = {vi_i[31], vi_i} - {vj_i[31], vj_i};
    if (dx[32] != dx[31]) begin
      d0 = dx[32] ? S32_MIN : S32_MAX;
    end else begin
      d0 = dx[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_DIFF]) begin
      d_q[0] <= d0;
    end
  end

  for (genvar s = 1; s <= ST_WPROD; s++) begin : g_dcarry
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        d_q[s] <= d_q[s-1];
      end
    end
  end

  // d*d
  logic [31:0] dm1;
  logic [63:0] sq_q;
  assign dm1 = d_q[ST_DIFF][31] ? 32'(-d_q[ST_DIFF]) : d_q[ST_DIFF];
  always_ff @(posedge clk_i) begin
    if (en_i[ST_SQ]) begin
      sq_q <= 64'(dm1) * 64'(dm1);
    end
  end

  // |gain| * s in two partial products
  logic [63:0]      s_full;
  logic [SW-1:0]    s_c;
  logic [32+SH-1:0]  plo_q;
  logic [32+SHW-1:0] phi_q;
  assign s_full = sq_q >> FracBits;
  assign s_c    = (s_full > 64'(SCap)) ? SCap : s_full[SW-1:0];
  always_ff @(posedge clk_i) begin
    if (en_i[ST_GPROD]) begin
      plo_q <= (32+SH)'(gm) * (32+SH)'(s_c[SH-1:0]);
      phi_q <= (32+SHW)'(gm) * (32+SHW)'(s_c[SW-1:SH]);
    end
  end

  logic [PW-1:0] gp;
  logic [PW-1:0] gps;
  logic [MW-1:0] m_q;
  assign gp  = (PW'(phi_q) << SH) + PW'(plo_q);
  assign gps = gp >> FracBits;
  always_ff @(posedge clk_i) begin
    if (en_i[ST_MAG]) begin
      m_q <= (gps > PW'(XCap)) ? XCap : gps[MW-1:0];
    end
  end

  // |x| * log2(e)
  logic [MW+30:0] ymf;
  logic [YW-1:0]  ym_q;
  assign ymf = (MW+31)'(m_q) * (MW+31)'(LOG2E_Q30);
  always_ff @(posedge clk_i) begin
    if (en_i[ST_LOG2]) begin
      ym_q <= ymf[MW+30:30];
    end
  end

  // integer / fraction split; a negative exponent borrows one from n
  logic [NW-1:0]       n0;
  logic [NW-1:0]       n1;
  logic [FracBits-1:0] f0;
  logic [FracBits-1:0] f1;
  logic [29:0]         f30;
  logic [59:0]         tf;
  logic [29:0]         t_q [ST_FRAC:ST_HLAST];
  logic [NW-1:0]       n_q [ST_FRAC:ST_HLAST];

  always_comb begin
    n0 = ym_q[YW-1:FracBits];
    f0 = ym_q[FracBits-1:0];
    if (gneg && (f0 != '0)) begin
      f1 = FracBits'(-f0);
      n1 = n0 + NW'(1);
    end else begin
      f1 = f0;
      n1 = n0;
    end
    f30 = 30'(f1) << (30 - FracBits);
    tf  = 60'(f30) * 60'(LN2_Q30);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_FRAC]) begin
      t_q[ST_FRAC] <= tf[59:30];
      n_q[ST_FRAC] <= n1;
    end
  end

  for (genvar s = ST_FRAC + 1; s <= ST_HLAST; s++) begin : g_tcarry
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        t_q[s] <= t_q[s-1];
        n_q[s] <= n_q[s-1];
      end
    end
  end

  // Horner series of e^(t), t = f*ln2, from the 1/8 term down
  logic [31:0] q_q [0:HORN_STEPS-1];
  logic [31:0] p_q [0:HORN_STEPS-1];

  for (genvar j = 0; j < HORN_STEPS; j++) begin : g_horn
    localparam int unsigned K   = HORN_STEPS - j;
    localparam int unsigned SA  = ST_HORN + 2 * j;
    localparam bit          P2  = ((K & (K - 1)) == 0);
    localparam logic [32:0] Rcp = 33'(((64'd1 << 34) + 64'(K) - 64'd1) / 64'(K));

    logic [31:0] pin;
    logic [61:0] qf;
    logic [31:0] qk;

    if (j == 0) begin : g_first
      assign pin = Q30_ONE;
    end else begin : g_next
      assign pin = p_q[j-1];
    end

    assign qf = 62'(t_q[SA-1]) * 62'(pin);

    always_ff @(posedge clk_i) begin
      if (en_i[SA]) begin
        q_q[j] <= qf[61:30];
      end
    end

    if (P2) begin : g_shift
      assign qk = q_q[j] >> $clog2(K);
    end else begin : g_recip
      logic [65:0] qr;
      assign qr = 66'(q_q[j]) * 66'(Rcp);
      assign qk = qr[34 +: 32];
    end

    always_ff @(posedge clk_i) begin
      if (en_i[SA+1]) begin
        p_q[j] <= Q30_ONE + qk;
      end
    end
  end

  // scale 2^frac by 2^n
  logic [31:0]   pf;
  logic [7:0]    nn;
  logic [7:0]    sh;
  logic [64:0]   pl;
  logic [EW-1:0] e_c;
  logic [EW-1:0] e_q;

  always_comb begin
    pf  = p_q[HORN_STEPS-1];
    nn  = 8'(n_q[ST_HLAST]);
    sh  = '0;
    pl  = '0;
    e_c = '0;
    if (!gneg) begin
      if ((nn + 8'(FracBits)) >= 8'd30) begin
        sh = nn + 8'(FracBits) - 8'd30;
        if (sh >= 8'd33) begin
          e_c = ECap;
        end else begin
          pl  = 65'(pf) << sh;
          e_c = (pl > 65'(ECap)) ? ECap : pl[EW-1:0];
        end
      end else begin
        sh  = 8'd30 - 8'(FracBits) - nn;
        e_c = EW'(pf >> sh);
      end
    end else begin
      sh = nn + 8'd30 - 8'(FracBits);
      if (sh >= 8'd63) begin
        e_c = '0;
      end else begin
        e_c = EW'(pf >> sh);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_EXP]) begin
      e_q <= e_c;
    end
  end

  // |d| * e in two partial products
  logic [31:0]       dm2;
  logic [32+EH-1:0]  wlo_q;
  logic [32+EHW-1:0] whi_q;
  assign dm2 = d_q[ST_EXP][31] ? 32'(-d_q[ST_EXP]) : d_q[ST_EXP];
  always_ff @(posedge clk_i) begin
    if (en_i[ST_WPROD]) begin
      wlo_q <= (32+EH)'(dm2) * (32+EH)'(e_q[EH-1:0]);
      whi_q <= (32+EHW)'(dm2) * (32+EHW)'(e_q[EW-1:EH]);
    end
  end

  logic [XW-1:0] wp;
  logic [XW-1:0] mag;
  logic          dneg;
  logic [31:0]   w_c;
  logic [31:0]   diff_q;
  logic [31:0]   weight_q;

  always_comb begin
    wp   = (XW'(whi_q) << EH) + XW'(wlo_q);
    mag  = wp >> FracBits;
    dneg = d_q[ST_WPROD][31];
    if (mag >= (XW'(1) << 31)) begin
      w_c = dneg ? S32_MIN : S32_MAX;
    end else begin
      w_c = dneg ? 32'(-mag[31:0]) : mag[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[ST_OUT]) begin
      diff_q   <= d_q[ST_WPROD];
      weight_q <= w_c;
    end
  end

  assign diff_o   = diff_q;
  assign weight_o = weight_q;

endmodule

`default_nettype wire

FILE: hdl/coupling_diff_exp_weight.sv
// Coupling weight block: for each lane d = vi - vj and w = d * exp(gain*d*d),
// signed fixed point with FRAC_BITS fraction bits (Q16.16 by default), every
// step truncating and both results saturating to 32 bits. One item is taken
// per clock while in_stall_o is low; each lane is a 25-stage pipeline, and a
// result on the output is taken at an edge when the output is not stalled.
// The depth is set
// by the exponential: a base-2 split of x*log2(e) followed by an eight-term
// Horner series, each term one multiply stage and one divide-by-constant
// stage. All lanes run in lockstep under one valid chain, and a bubble in the
// chain is squeezed out when the output stalls. exp_gain is written through
// the cfg port (always ready) and must only change while the block is empty.
// Lanes at or above LANES return zero difference and zero weight.
// Depends on cdew_pkg, cdew_ctl and cdew_lane.
`default_nettype none

module coupling_diff_exp_weight #(
  parameter int unsigned LANES     = cdew_pkg::LANES_DEF,
  parameter int unsigned FRAC_BITS = cdew_pkg::FRAC_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item in
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] vi_i,
  input  logic signed [31:0] vj_0_i,
  input  logic signed [31:0] vj_1_i,
  input  logic signed [31:0] vj_2_i,
  input  logic signed [31:0] vj_3_i,
  // result out
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] diff_0_o,
  output logic signed [31:0] diff_1_o,
  output logic signed [31:0] diff_2_o,
  output logic signed [31:0] diff_3_o,
  output logic signed [31:0] weight_0_o,
  output logic signed [31:0] weight_1_o,
  output logic signed [31:0] weight_2_o,
  output logic signed [31:0] weight_3_o,
  // exp_gain write
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i
);
  import cdew_pkg::*;

  logic [31:0]     gain_q;
  logic [NSTG-1:0] en;
  logic [31:0]     vj     [0:MAX_LANES-1];
  logic [31:0]     diff   [0:MAX_LANES-1];
  logic [31:0]     weight [0:MAX_LANES-1];

  // the gain register; config beats are always taken
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      gain_q <= cfg_data_i;
    end
  end

  cdew_ctl u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .en_o        (en)
  );

  assign vj[0] = vj_0_i;
  assign vj[1] = vj_1_i;
  assign vj[2] = vj_2_i;
  assign vj[3] = vj_3_i;

  for (genvar k = 0; k < MAX_LANES; k++) begin : g_lane
    if (k < LANES) begin : g_on
      cdew_lane #(
        .FracBits (FRAC_BITS)
      ) u_lane (
        .clk_i    (clk_i),
        .en_i     (en),
        .gain_i   (gain_q),
        .vi_i     (vi_i),
        .vj_i     (vj[k]),
        .diff_o   (diff[k]),
        .weight_o (weight[k])
      );
    end else begin : g_off
      assign diff[k]   = '0;
      assign weight[k] = '0;
    end
  end

  // merge lane results onto the result beat
  assign diff_0_o   = diff[0];
  assign diff_1_o   = diff[1];
  assign diff_2_o   = diff[2];
  assign diff_3_o   = diff[3];
  assign weight_0_o = weight[0];
  assign weight_1_o = weight[1];
  assign weight_2_o = weight[2];
  assign weight_3_o = weight[3];

  a_zero_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && diff_0_o == 32'sd0) |-> (weight_0_o == 32'sd0))
    else $error("nonzero weight for zero difference");

  a_weight_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && weight_0_o != 32'sd0) |-> (weight_0_o[31] == diff_0_o[31]))
    else $error("weight sign differs from difference sign");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

endmodule

`default_nettype wire

FILE: sim/tb_coupling_diff_exp_weight.sv
// Testbench for coupling_diff_exp_weight: per-lane difference and exp weight.
// Self-checking with a bit-true SystemVerilog predictor; depends on cdew_pkg and the RTL.
`timescale 1ns / 100ps

module tb_coupling_diff_exp_weight;
  import cdew_pkg::*;

  localparam int unsigned FRAC = FRAC_DEF;
  localparam int unsigned NL   = LANES_DEF;
  localparam int unsigned PIPE_LAT = NSTG + 8;

  typedef struct {
    logic signed [31:0] diff [MAX_LANES];
    logic signed [31:0] weight [MAX_LANES];
  } lane_res_t;

  // gain currently loaded into the block
  logic signed [31:0] gain_reg;

  // Q30 value of 2^(f / 2^F), Horner series of e^(f*ln2), truncating each step.
  function automatic logic [63:0] pow2_frac_q30(logic [63:0] f);
    logic [63:0] t;
    logic [63:0] p;
    t = ((f << (30 - FRAC)) * 64'(LN2_Q30)) >> 30;
    p = 64'(Q30_ONE);
    for (int k = 8; k >= 1; k--)
      p = 64'(Q30_ONE) + ((t * p) >> 30) / 64'(k);
    return p;
  endfunction

  // exp of +/- m in fixed point
  function automatic logic [63:0] exp_fx(logic [63:0] m, bit neg);
    logic [63:0] ecap;
    logic [63:0] ym;
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] p;
    longint sh;
    ecap = 64'd1 << (31 + FRAC);
    ym = (m * 64'(LOG2E_Q30)) >> 30;
    n  = ym >> FRAC;
    f  = ym & ((64'd1 << FRAC) - 1);
    if (!neg || m == 0) begin
      p  = pow2_frac_q30(f);
      sh = longint'(n) + FRAC - 30;
      if (sh >= 0) begin
        if (sh >= 33 || p > (ecap >> sh)) return ecap;
        p = p << sh;
        return (p > ecap) ? ecap : p;
      end
      return p >> (-sh);
    end
    if (f != 0) begin
      f = (64'd1 << FRAC) - f;
      n = n + 1;
    end
    p = pow2_frac_q30(f);
    if (n + 30 - FRAC >= 63) return 0;
    return p >> (n + 30 - FRAC);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [31:0] coupling_weight(longint d, logic signed [31:0] g);
    logic [63:0] dm;
    logic [63:0] gm;
    logic [63:0] s;
    logic [63:0] m;
    logic [63:0] e;
    logic [63:0] mag;
    logic [127:0] wide;
    longint gl;
    gl = g;
    dm = (d < 0) ? 64'(-d) : 64'(d);
    gm = (gl < 0) ? 64'(-gl) : 64'(gl);
    s  = (dm * dm) >> FRAC;
    wide = 128'(gm) * 128'(s);
    if (wide[127:64] != 0) m = 64'd32 << FRAC;
    else begin
      m = wide[63:0] >> FRAC;
      if (m > (64'd32 << FRAC)) m = 64'd32 << FRAC;
    end
    e = exp_fx(m, gl < 0);
    if (dm == 0) return 0;
    wide = 128'(dm) * 128'(e);
    if (wide[127:64] != 0) mag = 64'd1 << 32;
    else mag = wide[63:0] >> FRAC;
    if (mag > (64'd1 << 32)) mag = 64'd1 << 32;
    if (d < 0) return 32'(clamp32(-longint'(mag)));
    return 32'(clamp32(longint'(mag)));
  endfunction

  class coupling_scoreboard;
    lane_res_t pending[$];
    int mismatches;

    function void note_beat(logic signed [31:0] v, logic signed [31:0] vj [MAX_LANES],
                            logic signed [31:0] g);
      lane_res_t r;
      longint d;
      for (int k = 0; k < MAX_LANES; k++) begin
        r.diff[k] = 0;
        r.weight[k] = 0;
        if (k < NL) begin
          d = clamp32(longint'(v) - longint'(vj[k]));
          r.diff[k] = 32'(d);
          r.weight[k] = coupling_weight(d, g);
        end
      end
      pending.push_back(r);
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", what);
    endfunction

    function void check_beat(logic signed [31:0] df [MAX_LANES],
                             logic signed [31:0] wt [MAX_LANES]);
      lane_res_t x;
      if (pending.size() == 0) begin
        flag("result beat with nothing expected");
        return;
      end
      x = pending.pop_front();
      for (int k = 0; k < MAX_LANES; k++) begin
        if (df[k] !== x.diff[k])
          flag($sformatf("diff_%0d exp %0d got %0d", k, x.diff[k], df[k]));
        if (wt[k] !== x.weight[k])
          flag($sformatf("weight_%0d exp %0d got %0d", k, x.weight[k], wt[k]));
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] vi, vj [MAX_LANES];
  logic signed [31:0] dif [MAX_LANES];
  logic signed [31:0] wgt [MAX_LANES];
  logic cfg_valid, cfg_ready;
  logic [31:0] cfg_data;

  coupling_scoreboard sb;
  int send_idle_pct, recv_idle_pct;
  int hold_off;  // receiver hold-off cycles remaining

  coupling_diff_exp_weight DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .vi_i(vi), .vj_0_i(vj[0]), .vj_1_i(vj[1]), .vj_2_i(vj[2]), .vj_3_i(vj[3]),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .diff_0_o(dif[0]), .diff_1_o(dif[1]), .diff_2_o(dif[2]), .diff_3_o(dif[3]),
    .weight_0_o(wgt[0]), .weight_1_o(wgt[1]), .weight_2_o(wgt[2]), .weight_3_o(wgt[3]),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Safety net: far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // Receiver: random stall, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Result beats are sampled at the edge, before the new drive values settle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_beat(dif, wgt);
  end

  // Random voltage with heavy weight on the ranges that exercise the exponential.
  function automatic logic [31:0] pick_volt();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(65536 * 4)) - 65536 * 2);
      2: return 32'($signed($urandom_range(65536 * 40)) - 65536 * 20);
      3: return ($urandom_range(1)) ? 32'h7FFF_FFFF - $urandom_range(3)
                                   : 32'h8000_0000 + $urandom_range(3);
      default: return 32'($signed($urandom_range(65536 * 300)) - 65536 * 150);
    endcase
  endfunction

  // Offer one beat, hold it until accepted, and note it for prediction.
  // Valid stays up after acceptance so beats can follow back to back.
  task automatic send_beat(logic [31:0] a, logic [31:0] b0, logic [31:0] b1,
                           logic [31:0] b2, logic [31:0] b3);
    logic signed [31:0] nb [MAX_LANES];
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    nb[0] = b0; nb[1] = b1; nb[2] = b2; nb[3] = b3;
    vi <= a;
    for (int k = 0; k < MAX_LANES; k++) vj[k] <= nb[k];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_beat(a, nb, gain_reg);
  endtask

  task automatic send_random();
    send_beat(pick_volt(), pick_volt(), pick_volt(), pick_volt(), pick_volt());
  endtask

  // Let the pipeline empty, then load a new gain.
  task automatic write_gain(logic [31:0] g);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
    cfg_data  <= g;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gain_reg = g;
  endtask

  logic [31:0] gain_set [8];
  int wait_cycles;

  initial begin
    sb = new();
    rst_n = 0; in_valid = 0; out_stall = 0; cfg_valid = 0; cfg_data = 0;
    vi = 0; for (int k = 0; k < MAX_LANES; k++) vj[k] = 0;
    hold_off = 0;
    send_idle_pct = 0; recv_idle_pct = 0;
    gain_reg = GAIN_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset gain, field extremes, zero difference, saturating difference.
    send_beat(0, 0, 0, 0, 0);
    send_beat(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF);
    send_beat(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h0001_0000);
    send_beat(32'h0001_0000, 0, 32'h0002_0000, 32'hFFFF_0000, 32'h000A_0000);
    send_beat(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'h8000_0001);
    // zero gain: weight equals difference
    write_gain(0);
    send_beat(32'h0003_0000, 32'h8000_0000, 32'h1234_5678, 32'h7FFF_FFFF, 0);
    // huge positive gain: exponential saturates
    write_gain(32'h7FFF_FFFF);
    send_beat(32'h0000_0100, 0, 32'h0000_0101, 32'hFFFF_FF00, 32'h0001_0000);
    send_beat(32'h0001_0000, 0, 32'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    // most negative gain: exponential underflows to zero
    write_gain(32'h8000_0000);
    send_beat(32'h0001_0000, 0, 32'h0000_8000, 32'h0000_0010, 32'hFFFF_0000);
    // small positive gain
    write_gain(32'h0000_0800);
    send_beat(32'h0002_0000, 0, 32'hFFFE_0000, 32'h0010_0000, 32'h0000_4000);

    gain_set[0] = GAIN_RST;    gain_set[1] = 32'h0000_028F; gain_set[2] = 32'hFFFF_0000;
    gain_set[3] = 32'h0001_0000; gain_set[4] = 32'h8000_0000; gain_set[5] = 32'h7FFF_FFFF;
    gain_set[6] = 0;           gain_set[7] = 32'hFFFF_FFF0;

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 49 : 0;
      recv_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 32 : 0;
      for (int s = 0; s < 8; s++) begin
        write_gain((s == 7 && ph == 2) ? $urandom() : gain_set[s]);
        if (ph == 2 && s == 0) hold_off = 200;  // back-pressure fills the pipe
        for (int i = 0; i < 68; i++) send_random();
      end
    end
    in_valid <= 1'b0;

    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (PIPE_LAT) @(posedge clk);
    if (sb.pending.size() == 0 && sb.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/cdew_pkg.sv
hdl/cdew_ctl.sv
hdl/cdew_lane.sv
hdl/coupling_diff_exp_weight.sv
sim/tb_coupling_diff_exp_weight.sv
